// ----- hw/rtl/rtcsm_pkg.sv -----
// shared types, codes and bcd helpers for the three-wire rtc serial master
package rtcsm_pkg;

  // operation codes carried by an item
  localparam logic [1:0] OP_SINGLE_READ  = 2'd0;
  localparam logic [1:0] OP_SINGLE_WRITE = 2'd1;
  localparam logic [1:0] OP_BURST_READ   = 2'd2;
  localparam logic [1:0] OP_BURST_WRITE  = 2'd3;

  // io pin codes
  localparam logic [1:0] IO_LOW      = 2'd0;
  localparam logic [1:0] IO_HIGH     = 2'd1;
  localparam logic [1:0] IO_RELEASED = 2'd2;

  localparam logic [7:0]  CMD_BURST_READ     = 8'hBF;
  localparam logic [7:0]  CMD_BURST_WRITE    = 8'hBE;
  localparam logic [11:0] YEAR_BASE          = 12'd2000;
  localparam logic [11:0] YEAR_TOP           = 12'd2099;
  localparam logic [2:0]  ENABLE_SETUP_TICKS = 3'd4;
  localparam logic [2:0]  LAST_BIT           = 3'd7;
  localparam logic [2:0]  LAST_BYTE          = 3'd7;

  // burst byte positions
  localparam logic [2:0] BB_SECONDS = 3'd0;
  localparam logic [2:0] BB_MINUTES = 3'd1;
  localparam logic [2:0] BB_HOURS   = 3'd2;
  localparam logic [2:0] BB_DATE    = 3'd3;
  localparam logic [2:0] BB_MONTH   = 3'd4;
  localparam logic [2:0] BB_DOW     = 3'd5;
  localparam logic [2:0] BB_YEAR    = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_SECONDS      = 3'd0;
  localparam logic [2:0] REG_MINUTES      = 3'd1;
  localparam logic [2:0] REG_HOURS        = 3'd2;
  localparam logic [2:0] REG_DAY_OF_WEEK  = 3'd3;
  localparam logic [2:0] REG_DAY_OF_MONTH = 3'd4;
  localparam logic [2:0] REG_MONTH        = 3'd5;
  localparam logic [2:0] REG_YEAR         = 3'd6;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_SETUP = 8'b0000_0010,
    PH_WSET  = 8'b0000_0100,
    PH_WHIGH = 8'b0000_1000,
    PH_WLOW  = 8'b0001_0000,
    PH_RHIGH = 8'b0010_0000,
    PH_RLOW  = 8'b0100_0000,
    PH_HOLD  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [5:0]  set_seconds;
    logic [5:0]  set_minutes;
    logic [4:0]  set_hours;
    logic [2:0]  set_day_of_week;
    logic [4:0]  set_day_of_month;
    logic [3:0]  set_month;
    logic [11:0] set_year;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] opcode;
    logic [7:0] reg_address;
    logic [7:0] write_byte;
    logic       io_sample;
  } item_t;

  typedef struct packed {
    logic       sclk_level;
    logic [1:0] io_level;
    logic       chip_enable;
    logic       done_res;
  } pins_t;

  typedef struct packed {
    logic [6:0]  seconds;
    logic [6:0]  minutes;
    logic [5:0]  hours;
    logic [2:0]  day_of_week;
    logic [5:0]  day_of_month;
    logic [4:0]  month;
    logic [11:0] year;
  } time_t;

  // binary (below 100) to bcd, tens digit masked; tens by reciprocal multiply
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] v, input logic [3:0] tens_mask);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {7'd0, v} * 14'd103;
    tens  = prod[13:10];
    units = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
    return {tens & tens_mask, units[3:0]};
  endfunction

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b, input logic [3:0] tens_mask);
    logic [7:0] t;
    t = {4'd0, b[7:4] & tens_mask};
    return {t[4:0], 3'b000} + {t[6:0], 1'b0} + {4'd0, b[3:0]};
  endfunction

endpackage

// ----- hw/rtl/rtcsm_apb.sv -----
// apb register file holding the time to be written by a burst write
module rtcsm_apb (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtcsm_pkg::PADDR_W-1:0] paddr,
  input  logic [rtcsm_pkg::PDATA_W-1:0] pwdata,
  output logic [rtcsm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output rtcsm_pkg::cfg_t              cfg
);
  import rtcsm_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_seconds      <= 6'd0;
      cfg.set_minutes      <= 6'd0;
      cfg.set_hours        <= 5'd0;
      cfg.set_day_of_week  <= 3'd1;
      cfg.set_day_of_month <= 5'd1;
      cfg.set_month        <= 4'd1;
      cfg.set_year         <= YEAR_BASE;
    end else if (wr_en) begin
      unique case (idx)
        REG_SECONDS:      cfg.set_seconds      <= pwdata[5:0];
        REG_MINUTES:      cfg.set_minutes      <= pwdata[5:0];
        REG_HOURS:        cfg.set_hours        <= pwdata[4:0];
        REG_DAY_OF_WEEK:  cfg.set_day_of_week  <= pwdata[2:0];
        REG_DAY_OF_MONTH: cfg.set_day_of_month <= pwdata[4:0];
        REG_MONTH:        cfg.set_month        <= pwdata[3:0];
        REG_YEAR:         cfg.set_year         <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SECONDS:      prdata = {26'd0, cfg.set_seconds};
      REG_MINUTES:      prdata = {26'd0, cfg.set_minutes};
      REG_HOURS:        prdata = {27'd0, cfg.set_hours};
      REG_DAY_OF_WEEK:  prdata = {29'd0, cfg.set_day_of_week};
      REG_DAY_OF_MONTH: prdata = {27'd0, cfg.set_day_of_month};
      REG_MONTH:        prdata = {28'd0, cfg.set_month};
      REG_YEAR:         prdata = {20'd0, cfg.set_year};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/rtcsm_enc.sv -----
// bcd packing of the configured time into the bytes of a clock burst write
module rtcsm_enc (
  input  rtcsm_pkg::cfg_t cfg,
  input  logic [2:0]      byte_sel,
  output logic [7:0]      enc_byte
);
  import rtcsm_pkg::*;

  logic [6:0] year_off;

  // year minus base, clamped to 0..99
  always_comb begin
    if (cfg.set_year < YEAR_BASE) begin
      year_off = 7'd0;
    end else if (cfg.set_year > YEAR_TOP) begin
      year_off = 7'd99;
    end else begin
      year_off = 7'(cfg.set_year - YEAR_BASE);
    end
  end

  always_comb begin
    case (byte_sel)
      BB_SECONDS: enc_byte = bin_to_bcd({1'b0, cfg.set_seconds}, 4'd7);
      BB_MINUTES: enc_byte = bin_to_bcd({1'b0, cfg.set_minutes}, 4'd7);
      BB_HOURS:   enc_byte = bin_to_bcd({2'b0, cfg.set_hours}, 4'd3);
      BB_DATE:    enc_byte = bin_to_bcd({2'b0, cfg.set_day_of_month}, 4'd3);
      BB_MONTH:   enc_byte = bin_to_bcd({3'b0, cfg.set_month}, 4'd1);
      BB_DOW:     enc_byte = {5'd0, cfg.set_day_of_week};
      BB_YEAR:    enc_byte = bin_to_bcd(year_off, 4'd15);
      default:    enc_byte = 8'd0;
    endcase
  end

endmodule

// ----- hw/rtl/rtcsm_seq.sv -----
// bit sequencer: one phase step per tick item, burst store and time decode
module rtcsm_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  rtcsm_pkg::item_t item,
  input  logic [7:0]       enc_byte,
  output logic [2:0]       enc_sel,
  output rtcsm_pkg::pins_t pins,
  output logic [7:0]       read_byte,
  output rtcsm_pkg::time_t tm
);
  import rtcsm_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] op, op_next;
  logic [7:0] data_latched, data_latched_next;
  logic [2:0] bit_index, bit_index_next;
  logic [2:0] byte_index, byte_index_next;
  logic [2:0] tick_count, tick_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic       data_stage, data_stage_next;
  logic [7:0] burst_bytes [8];

  logic       cur_bit;
  logic [7:0] cmd;
  logic [7:0] rx_byte;
  logic       burst_we;
  logic       finish;

  assign cur_bit = shift_reg[bit_index];
  assign rx_byte = shift_reg | (8'(item.io_sample) << bit_index);
  // first data byte comes from slot zero, later ones from the next slot
  assign enc_sel = data_stage ? byte_index + 3'd1 : BB_SECONDS;

  always_comb begin
    case (item.opcode)
      OP_SINGLE_READ:  cmd = item.reg_address | 8'h01;
      OP_SINGLE_WRITE: cmd = item.reg_address & 8'hFE;
      OP_BURST_READ:   cmd = CMD_BURST_READ;
      default:         cmd = CMD_BURST_WRITE;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    op_next           = op;
    data_latched_next = data_latched;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    tick_count_next   = tick_count;
    shift_reg_next    = shift_reg;
    data_stage_next   = data_stage;
    burst_we          = 1'b0;
    finish            = 1'b0;
    pins.sclk_level   = 1'b0;
    pins.io_level     = IO_RELEASED;
    pins.chip_enable  = 1'b0;
    pins.done_res     = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          op_next           = item.opcode;
          data_latched_next = item.write_byte;
          shift_reg_next    = cmd;
          bit_index_next    = 3'd0;
          byte_index_next   = 3'd0;
          data_stage_next   = 1'b0;
          tick_count_next   = 3'd1;
          phase_next        = (3'd1 >= ENABLE_SETUP_TICKS) ? PH_WSET : PH_SETUP;
          pins.chip_enable  = 1'b1;
          pins.io_level     = IO_LOW;
        end
      end
      PH_SETUP: begin
        pins.chip_enable = 1'b1;
        pins.io_level    = IO_LOW;
        tick_count_next  = tick_count + 3'd1;
        if (tick_count_next >= ENABLE_SETUP_TICKS || tick_count_next == 3'd0) begin
          phase_next = PH_WSET;
        end
      end
      PH_WSET: begin
        pins.chip_enable = 1'b1;
        pins.io_level    = {1'b0, cur_bit};
        phase_next       = PH_WHIGH;
      end
      PH_WHIGH: begin
        pins.chip_enable = 1'b1;
        pins.sclk_level  = 1'b1;
        pins.io_level    = {1'b0, cur_bit};
        // read: release io after the last command bit, clock stays high
        if (!data_stage && bit_index == LAST_BIT &&
            (op == OP_SINGLE_READ || op == OP_BURST_READ)) begin
          phase_next      = PH_RHIGH;
          bit_index_next  = 3'd0;
          byte_index_next = 3'd0;
          shift_reg_next  = 8'd0;
        end else begin
          phase_next = PH_WLOW;
        end
      end
      PH_WLOW: begin
        pins.chip_enable = 1'b1;
        pins.io_level    = {1'b0, cur_bit};
        if (bit_index != LAST_BIT) begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = PH_WSET;
        end else begin
          bit_index_next = 3'd0;
          if (!data_stage) begin
            data_stage_next = 1'b1;
            byte_index_next = 3'd0;
            shift_reg_next  = (op == OP_SINGLE_WRITE) ? data_latched : enc_byte;
            phase_next      = PH_WSET;
          end else if (op == OP_BURST_WRITE && byte_index != LAST_BYTE) begin
            byte_index_next = byte_index + 3'd1;
            shift_reg_next  = enc_byte;
            phase_next      = PH_WSET;
          end else begin
            tick_count_next = 3'd0;
            phase_next      = PH_HOLD;
          end
        end
      end
      PH_RHIGH: begin
        pins.chip_enable = 1'b1;
        pins.sclk_level  = 1'b1;
        phase_next       = PH_RLOW;
      end
      PH_RLOW: begin
        pins.chip_enable = 1'b1;
        shift_reg_next   = rx_byte;
        if (bit_index != LAST_BIT) begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = PH_RHIGH;
        end else begin
          bit_index_next = 3'd0;
          burst_we       = 1'b1;
          if (op == OP_BURST_READ && byte_index != LAST_BYTE) begin
            byte_index_next = byte_index + 3'd1;
            shift_reg_next  = 8'd0;
            phase_next      = PH_RHIGH;
          end else begin
            tick_count_next = 3'd0;
            phase_next      = PH_HOLD;
          end
        end
      end
      PH_HOLD: begin
        tick_count_next = tick_count + 3'd1;
        if (tick_count_next >= ENABLE_SETUP_TICKS || tick_count_next == 3'd0) begin
          pins.done_res   = 1'b1;
          finish          = 1'b1;
          tick_count_next = 3'd0;
          phase_next      = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      op           <= OP_SINGLE_READ;
      data_latched <= 8'd0;
      bit_index    <= 3'd0;
      byte_index   <= 3'd0;
      tick_count   <= 3'd0;
      shift_reg    <= 8'd0;
      data_stage   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      op           <= op_next;
      data_latched <= data_latched_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      tick_count   <= tick_count_next;
      shift_reg    <= shift_reg_next;
      data_stage   <= data_stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && burst_we) begin
      burst_bytes[byte_index] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_byte <= 8'd0;
      tm        <= '{seconds: 7'd0, minutes: 7'd0, hours: 6'd0, day_of_week: 3'd0,
                     day_of_month: 6'd0, month: 5'd0, year: YEAR_BASE};
    end else if (step && finish) begin
      if (op == OP_SINGLE_READ) begin
        read_byte <= shift_reg;
      end else if (op == OP_BURST_READ) begin
        tm.seconds      <= 7'(bcd_to_bin(burst_bytes[BB_SECONDS], 4'd7));
        tm.minutes      <= 7'(bcd_to_bin(burst_bytes[BB_MINUTES], 4'd7));
        tm.hours        <= 6'(bcd_to_bin(burst_bytes[BB_HOURS], 4'd3));
        tm.day_of_month <= 6'(bcd_to_bin(burst_bytes[BB_DATE], 4'd3));
        tm.month        <= 5'(bcd_to_bin(burst_bytes[BB_MONTH], 4'd1));
        tm.day_of_week  <= burst_bytes[BB_DOW][2:0];
        tm.year         <= {4'd0, bcd_to_bin(burst_bytes[BB_YEAR], 4'd15)} + YEAR_BASE;
      end
    end
  end

endmodule

// ----- hw/rtl/three_wire_rtc_serial_master_unit.sv -----
// top level of the three-wire rtc serial master: item register, sequencer, result register
//
//   channel   handshake              payload
//   in        in_valid / in_ready    start_req opcode reg_address write_byte io_sample
//   out       out_valid / out_ready  pin levels, done_res, read_byte, decoded time
//   cfg       apb psel/penable       paddr pwdata prdata, pready tied high
//
// one tick item in, one result out; an item is taken every cycle while results drain.
// an item passes the item register, then the sequencer step into the result register.
// the sequencer state advances only as an item moves into the result register, so a
// stalled result holds the whole pipe; reset returns to idle with year 2000 decoded.
module three_wire_rtc_serial_master_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtcsm_pkg::PADDR_W-1:0] paddr,
  input  logic [rtcsm_pkg::PDATA_W-1:0] pwdata,
  output logic [rtcsm_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_req,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    reg_address,
  input  logic [7:0]                    write_byte,
  input  logic                          io_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          sclk_level,
  output logic [1:0]                    io_level,
  output logic                          chip_enable,
  output logic                          done_res,
  output logic [7:0]                    read_byte,
  output logic [6:0]                    seconds,
  output logic [6:0]                    minutes,
  output logic [5:0]                    hours,
  output logic [2:0]                    day_of_week,
  output logic [5:0]                    day_of_month,
  output logic [4:0]                    month,
  output logic [11:0]                   year
);
  import rtcsm_pkg::*;

  cfg_t       cfg;
  item_t      item_q;
  logic       item_valid;
  logic       step;
  pins_t      pins;
  pins_t      pins_q;
  time_t      tm;
  logic [2:0] enc_sel;
  logic [7:0] enc_byte;

  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  rtcsm_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rtcsm_enc u_enc (
    .cfg      (cfg),
    .byte_sel (enc_sel),
    .enc_byte (enc_byte)
  );

  rtcsm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item_q),
    .enc_byte  (enc_byte),
    .enc_sel   (enc_sel),
    .pins      (pins),
    .read_byte (read_byte),
    .tm        (tm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= '{start_req: start_req, opcode: opcode, reg_address: reg_address,
                  write_byte: write_byte, io_sample: io_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pins_q <= pins;
    end
  end

  assign sclk_level   = pins_q.sclk_level;
  assign io_level     = pins_q.io_level;
  assign chip_enable  = pins_q.chip_enable;
  assign done_res     = pins_q.done_res;
  // time fields change only with a step, so they match the held result
  assign seconds      = tm.seconds;
  assign minutes      = tm.minutes;
  assign hours        = tm.hours;
  assign day_of_week  = tm.day_of_week;
  assign day_of_month = tm.day_of_month;
  assign month        = tm.month;
  assign year         = tm.year;

endmodule
